// ----- rtl/core/spring_force_vector_top_assert.svh -----
// ----------------------------------------------------------------------------
// spring_force_vector_top_assert.svh
// assertion macros used by spring_force_vector_top
// ----------------------------------------------------------------------------
`ifndef SPRING_FORCE_VECTOR_TOP_ASSERT_SVH
`define SPRING_FORCE_VECTOR_TOP_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define SFV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("spring force vector assertion failed");
// next-cycle implication
`define SFV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("spring force vector assertion failed");
`else
`define SFV_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SFV_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/core/sfv_pkg.sv -----
// ----------------------------------------------------------------------------
// sfv_pkg
// widths, types and register codes of the spring force vector block
// ----------------------------------------------------------------------------
package sfv_pkg;

    // coordinate format
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // configuration port
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRING_CONSTANT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULL_ONLY       = 2'd2;

    // datapath widths
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int SUMSQ_W = 2 * DIFF_W;
    localparam int LEN_W   = DIFF_W;
    localparam int SQREM_W = LEN_W + 2;
    localparam int EXT_W   = (LEN_W > CFG_W) ? LEN_W : CFG_W;
    localparam int PROD_W  = CFG_W + EXT_W;
    localparam int MAG_W   = PROD_W - FRAC_BITS;
    localparam int MLO_W   = MAG_W / 2;
    localparam int MHI_W   = MAG_W - MLO_W;
    localparam int NUM_W   = MAG_W + DIFF_W;
    localparam int QUO_W   = COORD_WIDTH;
    localparam int REM_W   = LEN_W + 1;
    localparam int HI_W    = NUM_W - QUO_W;

    // request payloads
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] self_x;
        logic signed [COORD_WIDTH-1:0] self_y;
        logic signed [COORD_WIDTH-1:0] self_z;
        logic signed [COORD_WIDTH-1:0] other_x;
        logic signed [COORD_WIDTH-1:0] other_y;
        logic signed [COORD_WIDTH-1:0] other_z;
    } t_pos;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] force_x;
        logic signed [COORD_WIDTH-1:0] force_y;
        logic signed [COORD_WIDTH-1:0] force_z;
        logic                          force_applied;
    } t_force;

    // side data carried through the root chain
    typedef struct packed {
        logic [2:0][DIFF_W-1:0] ad;
        logic [2:0]             dneg;
    } t_sq_side;

    // side data carried through the divide chain
    typedef struct packed {
        logic [2:0] neg;
        logic [2:0] sat;
        logic       zero_out;
        logic       applied;
    } t_dv_side;

endpackage

// ----- rtl/core/sfv_stream_if.sv -----
// ----------------------------------------------------------------------------
// sfv_stream_if
// valid/ready channels for position requests and force results
// ----------------------------------------------------------------------------
interface sfv_pos_if;
    logic          valid;
    logic          ready;
    sfv_pkg::t_pos data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sfv_force_if;
    logic            valid;
    logic            ready;
    sfv_pkg::t_force data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/spring_force_vector_top.sv -----
// ----------------------------------------------------------------------------
// spring_force_vector_top
// Hooke's law spring force on a particle, signed fixed point, pipelined
// ----------------------------------------------------------------------------
// Each request on i_pos carries the particle position and the position of the
// other end (particle or anchor). One result leaves on o_force per request, in
// request order: force components saturated to the coordinate range and the
// force_applied flag (0 while a pull-only spring is slack).
// Stiffness, rest length and pull-only mode are written through the config
// port (index 0, 1, 2; other indexes are ignored). The user must write them
// only while no request is open; the block does not enforce this. There are
// 3 front stages, one stage per root bit of the square root chain (33 cells),
// 5 scale stages, one stage per quotient bit of the divide chain (32 cells)
// and the output register. The chain takes one request per cycle while it
// moves, each cell handing its data on. Reset clears all stage valids and
// the config registers (all to zero). When the receiver stalls, the output
// register holds its result; the chain keeps moving and taking requests
// until its last cell holds an item too, and only then does i_pos.ready drop.
// ----------------------------------------------------------------------------
`include "spring_force_vector_top_assert.svh"

module spring_force_vector_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sfv_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sfv_pkg::CFG_W-1:0]         i_cfg_data,
    sfv_pos_if.sink                           i_pos,
    sfv_force_if.source                       o_force
);
    localparam int NSQ = sfv_pkg::LEN_W;
    localparam int NDV = sfv_pkg::QUO_W;

    // config registers
    logic [sfv_pkg::CFG_W-1:0] r_k;
    logic [sfv_pkg::CFG_W-1:0] r_rest;
    logic                      r_pull;

    logic                      w_en;

    // front to root chain
    logic                                w_fv;
    logic [sfv_pkg::SUMSQ_W-1:0]         w_fsum;
    sfv_pkg::t_sq_side                   w_fside;

    logic                                w_sq_v    [NSQ+1];
    logic [sfv_pkg::SUMSQ_W-1:0]         w_sq_rad  [NSQ+1];
    logic [sfv_pkg::SQREM_W-1:0]         w_sq_rem  [NSQ+1];
    logic [sfv_pkg::LEN_W-1:0]           w_sq_root [NSQ+1];
    sfv_pkg::t_sq_side                   w_sq_side [NSQ+1];

    logic                                w_dv_v    [NDV+1];
    logic [sfv_pkg::LEN_W-1:0]           w_dv_len  [NDV+1];
    logic [2:0][sfv_pkg::REM_W-1:0]      w_dv_rem  [NDV+1];
    logic [2:0][sfv_pkg::QUO_W-1:0]      w_dv_low  [NDV+1];
    logic [2:0][sfv_pkg::QUO_W-1:0]      w_dv_quo  [NDV+1];
    sfv_pkg::t_dv_side                   w_dv_side [NDV+1];

    logic                                w_last_v;
    logic                                w_load;
    logic [2:0][sfv_pkg::QUO_W-1:0]      w_lim;
    logic [2:0][sfv_pkg::QUO_W-1:0]      w_mag;
    logic [2:0][sfv_pkg::QUO_W-1:0]      w_f;
    sfv_pkg::t_force                     n_out;

    logic                                r_out_valid;
    sfv_pkg::t_force                     r_out;

    // config write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_rest <= '0;
            r_pull <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sfv_pkg::CFG_SPRING_CONSTANT: r_k    <= i_cfg_data;
                sfv_pkg::CFG_REST_LENGTH:     r_rest <= i_cfg_data;
                sfv_pkg::CFG_PULL_ONLY:       r_pull <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // chain moves unless its last cell is full and the output cannot take it
    assign w_last_v    = w_dv_v[NDV];
    assign w_en        = !w_last_v || !r_out_valid || o_force.ready;
    assign w_load      = w_last_v && (!r_out_valid || o_force.ready);
    assign i_pos.ready = w_en;

    sfv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_pos.valid),
        .i_pos   (i_pos.data),
        .o_valid (w_fv),
        .o_sumsq (w_fsum),
        .o_side  (w_fside)
    );

    // square root chain
    assign w_sq_v[0]    = w_fv;
    assign w_sq_rad[0]  = w_fsum;
    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;
    assign w_sq_side[0] = w_fside;

    for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
        sfv_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_v[g]),
            .i_rad   (w_sq_rad[g]),
            .i_rem   (w_sq_rem[g]),
            .i_root  (w_sq_root[g]),
            .i_side  (w_sq_side[g]),
            .o_valid (w_sq_v[g+1]),
            .o_rad   (w_sq_rad[g+1]),
            .o_rem   (w_sq_rem[g+1]),
            .o_root  (w_sq_root[g+1]),
            .o_side  (w_sq_side[g+1])
        );
    end

    sfv_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_v[NSQ]),
        .i_len   (w_sq_root[NSQ]),
        .i_side  (w_sq_side[NSQ]),
        .i_k     (r_k),
        .i_rest  (r_rest),
        .i_pull  (r_pull),
        .o_valid (w_dv_v[0]),
        .o_len   (w_dv_len[0]),
        .o_rem   (w_dv_rem[0]),
        .o_low   (w_dv_low[0]),
        .o_side  (w_dv_side[0])
    );
    assign w_dv_quo[0] = '0;

    // divide chain
    for (genvar g = 0; g < NDV; g++) begin : g_div
        sfv_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv_v[g]),
            .i_len   (w_dv_len[g]),
            .i_rem   (w_dv_rem[g]),
            .i_low   (w_dv_low[g]),
            .i_quo   (w_dv_quo[g]),
            .i_side  (w_dv_side[g]),
            .o_valid (w_dv_v[g+1]),
            .o_len   (w_dv_len[g+1]),
            .o_rem   (w_dv_rem[g+1]),
            .o_low   (w_dv_low[g+1]),
            .o_quo   (w_dv_quo[g+1]),
            .o_side  (w_dv_side[g+1])
        );
    end

    // saturate, apply sign, zero out slack or zero-length cases
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_lim[i] = w_dv_side[NDV].neg[i]
                     ? {1'b1, {(sfv_pkg::QUO_W-1){1'b0}}}
                     : {1'b0, {(sfv_pkg::QUO_W-1){1'b1}}};
            w_mag[i] = (w_dv_side[NDV].sat[i] || (w_dv_quo[NDV][i] > w_lim[i]))
                     ? w_lim[i] : w_dv_quo[NDV][i];
            w_f[i]   = w_dv_side[NDV].zero_out ? '0
                     : (w_dv_side[NDV].neg[i] ? (~w_mag[i] + 1'b1) : w_mag[i]);
        end
        n_out.force_x       = w_f[0];
        n_out.force_y       = w_f[1];
        n_out.force_z       = w_f[2];
        n_out.force_applied = w_dv_side[NDV].applied;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_force.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_force.valid = r_out_valid;
    assign o_force.data  = r_out;

    // the remainders and leftover numerator bits end with the chain
    logic w_unused_tail;
    assign w_unused_tail = ^{w_dv_rem[NDV], w_dv_low[NDV], w_dv_len[NDV],
                             w_sq_rad[NSQ], w_sq_rem[NSQ]};

    // checks
    `SFV_ASSERT_IMP(a_slack_zero, i_clk, i_rst_n,
        r_out_valid && !r_out.force_applied,
        (r_out.force_x == '0) && (r_out.force_y == '0) && (r_out.force_z == '0))
    `SFV_ASSERT_IMP(a_applied_no_pull, i_clk, i_rst_n,
        r_out_valid && !r_pull, r_out.force_applied)
    `SFV_ASSERT_NXT(a_last_held, i_clk, i_rst_n,
        w_last_v && r_out_valid && !o_force.ready, w_last_v)
endmodule

// ----- rtl/core/sfv_front.sv -----
// ----------------------------------------------------------------------------
// sfv_front
// separation vector, component squares and squared length
// ----------------------------------------------------------------------------
module sfv_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  sfv_pkg::t_pos                       i_pos,
    output logic                                o_valid,
    output logic [sfv_pkg::SUMSQ_W-1:0]         o_sumsq,
    output sfv_pkg::t_sq_side                   o_side
);
    logic [2:0][sfv_pkg::COORD_WIDTH-1:0] w_a;
    logic [2:0][sfv_pkg::COORD_WIDTH-1:0] w_b;
    logic [2:0][sfv_pkg::DIFF_W-1:0]      w_d;
    sfv_pkg::t_sq_side                    n_side_a;

    logic                                 r_va, r_vb, r_vc;
    sfv_pkg::t_sq_side                    r_side_a, r_side_b, r_side_c;
    logic [2:0][sfv_pkg::SUMSQ_W-1:0]     r_sq;
    logic [sfv_pkg::SUMSQ_W-1:0]          r_sum;

    assign w_a = {i_pos.self_z, i_pos.self_y, i_pos.self_x};
    assign w_b = {i_pos.other_z, i_pos.other_y, i_pos.other_x};

    // sign-extended difference and its magnitude
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i] = {w_a[i][sfv_pkg::COORD_WIDTH-1], w_a[i]}
                   - {w_b[i][sfv_pkg::COORD_WIDTH-1], w_b[i]};
            n_side_a.dneg[i] = w_d[i][sfv_pkg::DIFF_W-1];
            n_side_a.ad[i]   = n_side_a.dneg[i] ? (~w_d[i] + 1'b1) : w_d[i];
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    // difference, squares, sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side_a <= n_side_a;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_side_a.ad[i] * r_side_a.ad[i];
            end
            r_side_b <= r_side_a;
            r_sum    <= r_sq[0] + r_sq[1] + r_sq[2];
            r_side_c <= r_side_b;
        end
    end

    assign o_valid = r_vc;
    assign o_sumsq = r_sum;
    assign o_side  = r_side_c;
endmodule

// ----- rtl/core/sfv_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// sfv_sqrt_cell
// one root digit of the integer square root chain
// ----------------------------------------------------------------------------
module sfv_sqrt_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [sfv_pkg::SUMSQ_W-1:0]   i_rad,
    input  logic [sfv_pkg::SQREM_W-1:0]   i_rem,
    input  logic [sfv_pkg::LEN_W-1:0]     i_root,
    input  sfv_pkg::t_sq_side             i_side,
    output logic                          o_valid,
    output logic [sfv_pkg::SUMSQ_W-1:0]   o_rad,
    output logic [sfv_pkg::SQREM_W-1:0]   o_rem,
    output logic [sfv_pkg::LEN_W-1:0]     o_root,
    output sfv_pkg::t_sq_side             o_side
);
    logic [sfv_pkg::SQREM_W-1:0] w_rsh;
    logic [sfv_pkg::SQREM_W-1:0] w_trial;
    logic                        w_ge;

    logic                        r_valid;
    logic [sfv_pkg::SUMSQ_W-1:0] r_rad;
    logic [sfv_pkg::SQREM_W-1:0] r_rem;
    logic [sfv_pkg::LEN_W-1:0]   r_root;
    sfv_pkg::t_sq_side           r_side;

    // bring down two radicand bits, try root*4+1
    assign w_rsh   = {i_rem[sfv_pkg::LEN_W-1:0],
                      i_rad[sfv_pkg::SUMSQ_W-1:sfv_pkg::SUMSQ_W-2]};
    assign w_trial = {i_root, 2'b01};
    assign w_ge    = (w_rsh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= {i_rad[sfv_pkg::SUMSQ_W-3:0], 2'b00};
            r_rem  <= w_ge ? (w_rsh - w_trial) : w_rsh;
            r_root <= {i_root[sfv_pkg::LEN_W-2:0], w_ge};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;
endmodule

// ----- rtl/core/sfv_scale.sv -----
// ----------------------------------------------------------------------------
// sfv_scale
// extension, force magnitude products and divide setup
// ----------------------------------------------------------------------------
module sfv_scale (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic [sfv_pkg::LEN_W-1:0]              i_len,
    input  sfv_pkg::t_sq_side                      i_side,
    input  logic [sfv_pkg::CFG_W-1:0]              i_k,
    input  logic [sfv_pkg::CFG_W-1:0]              i_rest,
    input  logic                                   i_pull,
    output logic                                   o_valid,
    output logic [sfv_pkg::LEN_W-1:0]              o_len,
    output logic [2:0][sfv_pkg::REM_W-1:0]         o_rem,
    output logic [2:0][sfv_pkg::QUO_W-1:0]         o_low,
    output sfv_pkg::t_dv_side                      o_side
);
    localparam int PH_W = sfv_pkg::MHI_W + sfv_pkg::DIFF_W;
    localparam int PL_W = sfv_pkg::MLO_W + sfv_pkg::DIFF_W;

    logic [sfv_pkg::EXT_W:0]      w_ext;
    logic [sfv_pkg::EXT_W:0]      w_ext_abs;
    logic [sfv_pkg::PROD_W-1:0]   w_prod;
    logic [2:0]                   w_neg;
    logic [2:0][sfv_pkg::HI_W-1:0] w_hi;

    // valids of the five stages
    logic r_ve, r_v1, r_v2, r_v3, r_v4;

    // extension stage
    logic [sfv_pkg::EXT_W-1:0]    r_aext;
    logic                         r_eneg, r_ezero, r_slack, r_lzero;
    logic [sfv_pkg::LEN_W-1:0]    r_len_e, r_len_1, r_len_2, r_len_3, r_len_4;
    sfv_pkg::t_sq_side            r_side_e, r_side_1, r_side_2;

    // flags carried to the divide setup
    logic                         r_eneg_1, r_ezero_1, r_slack_1, r_lzero_1;
    logic                         r_eneg_2, r_ezero_2, r_slack_2, r_lzero_2;
    logic                         r_zero_3, r_applied_3;
    logic [2:0]                   r_neg_3;

    // products
    logic [sfv_pkg::MAG_W-1:0]    r_mag;
    logic [2:0][PH_W-1:0]         r_ph;
    logic [2:0][PL_W-1:0]         r_pl;
    logic [2:0][sfv_pkg::NUM_W-1:0] r_num;

    // divide setup
    logic [2:0][sfv_pkg::REM_W-1:0] r_rem;
    logic [2:0][sfv_pkg::QUO_W-1:0] r_low;
    sfv_pkg::t_dv_side             r_dside;

    // signed extension L - rest
    assign w_ext     = (sfv_pkg::EXT_W+1)'(i_len) - (sfv_pkg::EXT_W+1)'(i_rest);
    assign w_ext_abs = w_ext[sfv_pkg::EXT_W] ? (~w_ext + 1'b1) : w_ext;
    assign w_prod    = sfv_pkg::PROD_W'(i_k) * sfv_pkg::PROD_W'(r_aext);

    // force sign per lane, zero components carry no sign
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_neg[i] = !r_ezero_2 && (r_side_2.ad[i] != '0)
                     && (r_eneg_2 == r_side_2.dneg[i]);
            w_hi[i]  = r_num[i][sfv_pkg::NUM_W-1:sfv_pkg::QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_ve <= i_valid;
            r_v1 <= r_ve;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // extension and slack test
            r_aext   <= w_ext_abs[sfv_pkg::EXT_W-1:0];
            r_eneg   <= w_ext[sfv_pkg::EXT_W];
            r_ezero  <= (w_ext == '0);
            r_slack  <= i_pull && (w_ext[sfv_pkg::EXT_W] || (w_ext == '0));
            r_lzero  <= (i_len == '0);
            r_len_e  <= i_len;
            r_side_e <= i_side;

            // m = k * |ext| in Q.F
            r_mag     <= w_prod[sfv_pkg::PROD_W-1:sfv_pkg::FRAC_BITS];
            r_eneg_1  <= r_eneg;
            r_ezero_1 <= r_ezero;
            r_slack_1 <= r_slack;
            r_lzero_1 <= r_lzero;
            r_len_1   <= r_len_e;
            r_side_1  <= r_side_e;

            // split partial products of m * |d|
            for (int i = 0; i < 3; i++) begin
                r_ph[i] <= PH_W'(r_mag[sfv_pkg::MAG_W-1:sfv_pkg::MLO_W])
                         * PH_W'(r_side_1.ad[i]);
                r_pl[i] <= PL_W'(r_mag[sfv_pkg::MLO_W-1:0]) * PL_W'(r_side_1.ad[i]);
            end
            r_eneg_2  <= r_eneg_1;
            r_ezero_2 <= r_ezero_1;
            r_slack_2 <= r_slack_1;
            r_lzero_2 <= r_lzero_1;
            r_len_2   <= r_len_1;
            r_side_2  <= r_side_1;

            // combine partial products
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= {r_ph[i], {sfv_pkg::MLO_W{1'b0}}}
                          + sfv_pkg::NUM_W'(r_pl[i]);
            end
            r_neg_3     <= w_neg;
            r_zero_3    <= r_slack_2 || r_lzero_2;
            r_applied_3 <= !r_slack_2;
            r_len_3     <= r_len_2;

            // overflow test and first partial remainder
            for (int i = 0; i < 3; i++) begin
                r_dside.sat[i] <= (w_hi[i] >= sfv_pkg::HI_W'(r_len_3));
                r_rem[i]       <= sfv_pkg::REM_W'(w_hi[i][sfv_pkg::LEN_W-1:0]);
                r_low[i]       <= r_num[i][sfv_pkg::QUO_W-1:0];
            end
            r_dside.neg      <= r_neg_3;
            r_dside.zero_out <= r_zero_3;
            r_dside.applied  <= r_applied_3;
            r_len_4          <= r_len_3;
        end
    end

    assign o_valid = r_v4;
    assign o_len   = r_len_4;
    assign o_rem   = r_rem;
    assign o_low   = r_low;
    assign o_side  = r_dside;
endmodule

// ----- rtl/core/sfv_div_cell.sv -----
// ----------------------------------------------------------------------------
// sfv_div_cell
// one quotient bit of the three-lane restoring divide chain
// ----------------------------------------------------------------------------
module sfv_div_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [sfv_pkg::LEN_W-1:0]         i_len,
    input  logic [2:0][sfv_pkg::REM_W-1:0]    i_rem,
    input  logic [2:0][sfv_pkg::QUO_W-1:0]    i_low,
    input  logic [2:0][sfv_pkg::QUO_W-1:0]    i_quo,
    input  sfv_pkg::t_dv_side                 i_side,
    output logic                              o_valid,
    output logic [sfv_pkg::LEN_W-1:0]         o_len,
    output logic [2:0][sfv_pkg::REM_W-1:0]    o_rem,
    output logic [2:0][sfv_pkg::QUO_W-1:0]    o_low,
    output logic [2:0][sfv_pkg::QUO_W-1:0]    o_quo,
    output sfv_pkg::t_dv_side                 o_side
);
    logic [2:0][sfv_pkg::REM_W-1:0] w_rsh;
    logic [2:0]                     w_ge;

    logic                           r_valid;
    logic [sfv_pkg::LEN_W-1:0]      r_len;
    logic [2:0][sfv_pkg::REM_W-1:0] r_rem;
    logic [2:0][sfv_pkg::QUO_W-1:0] r_low;
    logic [2:0][sfv_pkg::QUO_W-1:0] r_quo;
    sfv_pkg::t_dv_side              r_side;

    // shift in next numerator bit and trial subtract
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rsh[i] = {i_rem[i][sfv_pkg::LEN_W-1:0], i_low[i][sfv_pkg::QUO_W-1]};
            w_ge[i]  = (w_rsh[i] >= sfv_pkg::REM_W'(i_len));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_rem[i] <= w_ge[i] ? (w_rsh[i] - sfv_pkg::REM_W'(i_len)) : w_rsh[i];
                r_low[i] <= {i_low[i][sfv_pkg::QUO_W-2:0], 1'b0};
                r_quo[i] <= {i_quo[i][sfv_pkg::QUO_W-2:0], w_ge[i]};
            end
            r_len  <= i_len;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_len   = r_len;
    assign o_rem   = r_rem;
    assign o_low   = r_low;
    assign o_quo   = r_quo;
    assign o_side  = r_side;
endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for spring_force_vector_top
// ----------------------------------------------------------------------------
// A directed table covers the reset setting, field extremes, zero separation,
// a slack bungee, length equal to rest and saturation. A random stream then
// runs through several spring settings and handshake idling phases. Every
// result is checked field by field against its table entry or a bit-exact
// Hooke's law force predictor.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RANDOM_ITEMS = 1200;
    localparam int  DRAIN_CYCLES = 120;
    localparam int  CYCLE_LIMIT  = 2000000;
    localparam int  Q_ONE        = 32'h0001_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [sfv_pkg::CFG_IDX_W-1:0] i_cfg_idx = sfv_pkg::CFG_SPRING_CONSTANT;
    logic [sfv_pkg::CFG_W-1:0] i_cfg_data = '0;

    sfv_pos_if   pos_if ();
    sfv_force_if force_if ();

    spring_force_vector_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pos      (pos_if),
        .o_force    (force_if)
    );

    always #5 i_clk = ~i_clk;

    // spring settings mirrored for the force predictor
    logic [31:0] stiffness = '0;
    logic [31:0] rest_len  = '0;
    logic        bungee    = 1'b0;

    sfv_pkg::t_force expected_forces[$];
    int     errors = 0;
    int     results_seen = 0;
    int     slack_seen = 0;
    int     saturated_seen = 0;
    longint cycles = 0;
    int     sender_idle_pct = 0;
    int     stall_pct = 0;

    initial begin
        pos_if.valid = 1'b0;
        pos_if.data = '0;
        force_if.ready = 1'b0;
    end

    // bit-exact Hooke's law force from the mirrored settings
    function automatic sfv_pkg::t_force spring_force(sfv_pkg::t_pos p);
        logic signed [32:0] d[3];
        logic [32:0]        a33;
        logic [127:0]       ad[3];
        logic [127:0]       sumsq;
        logic [127:0]       len;
        logic [127:0]       c;
        logic [127:0]       m;
        logic [127:0]       q;
        logic [127:0]       lim;
        logic signed [35:0] ext;
        logic [35:0]        aext;
        logic               neg;
        logic [31:0]        val[3];
        sfv_pkg::t_force    f;
        d[0] = p.self_x - p.other_x;
        d[1] = p.self_y - p.other_y;
        d[2] = p.self_z - p.other_z;
        sumsq = '0;
        for (int i = 0; i < 3; i++) begin
            a33 = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
            ad[i] = {95'b0, a33};
            sumsq = sumsq + ad[i] * ad[i];
        end
        len = '0;
        for (int b = 63; b >= 0; b--) begin
            c = len | (128'd1 << b);
            if (c * c <= sumsq) len = c;
        end
        f = '0;
        f.force_applied = 1'b1;
        // slack bungee, zero separation
        if (bungee && len <= {96'b0, rest_len}) begin
            f.force_applied = 1'b0;
            return f;
        end
        if (len == 0) return f;
        ext = $signed({2'b0, len[33:0]}) - $signed({4'b0, rest_len});
        aext = ext < 0 ? 36'(-ext) : 36'(ext);
        m = ({96'b0, stiffness} * {92'b0, aext}) >> sfv_pkg::FRAC_BITS;
        for (int i = 0; i < 3; i++) begin
            q = (m * ad[i]) / len;
            neg = (ext > 0) == (d[i] > 0);
            if (ext == 0 || d[i] == 0) neg = 1'b0;
            lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
            if (q > lim) q = lim;
            val[i] = neg ? -q[31:0] : q[31:0];
        end
        f.force_x = val[0];
        f.force_y = val[1];
        f.force_z = val[2];
        return f;
    endfunction

    // receiver stalls and result checking
    always @(posedge i_clk) begin
        sfv_pkg::t_force exp_f;
        sfv_pkg::t_force got;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** spring_force_vector_top: FAILED **");
            $finish;
        end
        force_if.ready <= i_rst_n && ($urandom_range(99) >= stall_pct);
        if (i_rst_n && force_if.valid && force_if.ready) begin
            got = force_if.data;
            results_seen++;
            if (!got.force_applied) slack_seen++;
            if (got.force_x == 32'sh7fffffff || got.force_x == 32'sh80000000)
                saturated_seen++;
            if (expected_forces.size() == 0) begin
                $error("force result with no request waiting");
                errors++;
            end else begin
                exp_f = expected_forces.pop_front();
                if (got.force_x !== exp_f.force_x) begin
                    $error("force_x expected %h actual %h", exp_f.force_x, got.force_x);
                    errors++;
                end
                if (got.force_y !== exp_f.force_y) begin
                    $error("force_y expected %h actual %h", exp_f.force_y, got.force_y);
                    errors++;
                end
                if (got.force_z !== exp_f.force_z) begin
                    $error("force_z expected %h actual %h", exp_f.force_z, got.force_z);
                    errors++;
                end
                if (got.force_applied !== exp_f.force_applied) begin
                    $error("force_applied expected %b actual %b",
                           exp_f.force_applied, got.force_applied);
                    errors++;
                end
            end
        end
    end

    // wait for the pipeline to empty and settle
    task automatic drain();
        while (expected_forces.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [sfv_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // retune the spring while idle, mirror into the predictor
    task automatic set_spring(logic [31:0] k, logic [31:0] rest, logic pull);
        pos_if.valid <= 1'b0;
        drain();
        write_reg(sfv_pkg::CFG_SPRING_CONSTANT, k);
        write_reg(sfv_pkg::CFG_REST_LENGTH, rest);
        write_reg(sfv_pkg::CFG_PULL_ONLY, {31'b0, pull});
        stiffness = k;
        rest_len = rest;
        bungee = pull;
    endtask

    // present one request, hold until taken, then maybe go idle
    task automatic send(sfv_pkg::t_pos p, sfv_pkg::t_force exp_f);
        pos_if.valid <= 1'b1;
        pos_if.data <= p;
        do @(posedge i_clk); while (!pos_if.ready);
        expected_forces = {expected_forces, exp_f};
        if ($urandom_range(99) < sender_idle_pct) begin
            pos_if.valid <= 1'b0;
            pos_if.data <= '0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
    endtask

    function automatic sfv_pkg::t_pos random_pos();
        sfv_pkg::t_pos p;
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        // mostly nearby ends so that forces stay in range
        if ($urandom_range(3) != 0) begin
            p.other_x = p.self_x + $signed($urandom_range(32'h000f_ffff) - 32'h0008_0000);
            p.other_y = p.self_y + $signed($urandom_range(32'h000f_ffff) - 32'h0008_0000);
            p.other_z = p.self_z + $signed($urandom_range(32'h000f_ffff) - 32'h0008_0000);
        end
        return p;
    endfunction

    typedef struct {
        logic [31:0]     k;
        logic [31:0]     rest;
        logic            pull;
        sfv_pkg::t_pos   p;
        logic            typed;
        sfv_pkg::t_force f;
    } t_row;

    localparam logic [31:0] MAXP = 32'h7fff_ffff;
    localparam logic [31:0] MINP = 32'h8000_0000;
    localparam logic [31:0] ZP   = 32'h0;

    t_row directed[] = '{
        // reset setting: no stiffness, every force zero
        '{0, 0, 0, {6{32'h0}}, 1, '{0, 0, 0, 1}},
        '{0, 0, 0, {MAXP, MAXP, MAXP, MINP, MINP, MINP}, 1, '{0, 0, 0, 1}},
        '{0, 0, 0, {MINP, MINP, MINP, MAXP, MAXP, MAXP}, 1, '{0, 0, 0, 1}},
        '{0, 0, 0, {32'hffffffff, 32'h1, 32'h0, 32'h1, 32'hffffffff, 32'h0}, 1, '{0,0,0,1}},
        // unit stiffness, zero rest
        '{Q_ONE, 0, 0, {6{32'h0}}, 1, '{0, 0, 0, 1}},
        '{Q_ONE, 0, 0, {32'h0003_0000, 32'h0004_0000, ZP, ZP, ZP, ZP}, 0, '{0, 0, 0, 0}},
        '{Q_ONE, 0, 0, {MAXP, MAXP, MAXP, MINP, MINP, MINP}, 0, '{0, 0, 0, 0}},
        '{Q_ONE, 0, 0, {MINP, MAXP, 32'h0, MAXP, MINP, 32'h0}, 0, '{0, 0, 0, 0}},
        '{Q_ONE, 0, 0, {32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 0, '{0, 0, 0, 0}},
        // length equal to rest gives zero force
        '{Q_ONE, 32'h0005_0000, 0, {32'h0003_0000, 32'h0004_0000, ZP, ZP, ZP, ZP}, 1,
          '{0, 0, 0, 1}},
        '{Q_ONE, 32'h0005_0000, 0, {32'h0001_0000, ZP, ZP, ZP, ZP, ZP}, 0, '{0, 0, 0, 0}},
        // bungee: slack, zero separation, stretched
        '{Q_ONE, 32'h0005_0000, 1, {32'h0001_0000, ZP, ZP, ZP, ZP, ZP}, 1, '{0, 0, 0, 0}},
        '{Q_ONE, 32'h0005_0000, 1, {6{32'h0}}, 1, '{0, 0, 0, 0}},
        '{Q_ONE, 32'h0005_0000, 1, {32'h0003_0000, 32'h0004_0000, ZP, ZP, ZP, ZP}, 1,
          '{0, 0, 0, 0}},
        '{Q_ONE, 32'h0005_0000, 1, {32'h0009_0000, 32'hfff0_0000, ZP, ZP, ZP, ZP}, 0,
          '{0, 0, 0, 0}},
        '{0, 0, 1, {6{32'h0}}, 1, '{0, 0, 0, 0}},
        // extreme stiffness and rest
        '{32'hffffffff, 32'hffffffff, 0, {MAXP, ZP, ZP, MINP, ZP, ZP}, 0, '{0, 0, 0, 0}},
        '{32'hffffffff, 32'hffffffff, 0, {32'h1, 32'h1, 32'h1, ZP, ZP, ZP}, 0, '{0,0,0,0}},
        '{32'hffffffff, 0, 0, {32'h0001_0000, 32'hffff_0000, 32'h5, ZP, ZP, ZP}, 0,
          '{0, 0, 0, 0}},
        '{32'hffffffff, 32'hffffffff, 1, {MAXP, MAXP, MAXP, MINP, MINP, MINP}, 0,
          '{0, 0, 0, 0}}
    };

    initial begin
        sfv_pkg::t_pos   p;
        sfv_pkg::t_force f;
        int              n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed[r]) begin
            if (directed[r].k != stiffness || directed[r].rest != rest_len ||
                directed[r].pull != bungee)
                set_spring(directed[r].k, directed[r].rest, directed[r].pull);
            f = directed[r].typed ? directed[r].f : spring_force(directed[r].p);
            send(directed[r].p, f);
        end
        pos_if.valid <= 1'b0;

        // random stream over idling phases and spring settings
        n = 0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 76; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 76; end
                default: begin sender_idle_pct = 22; stall_pct = 22; end
            endcase
            for (int s = 0; s < 3; s++) begin
                pos_if.valid <= 1'b0;
                case ($urandom_range(4))
                    0: set_spring(32'hffffffff, $urandom, 1'($urandom_range(1)));
                    1: set_spring($urandom, 32'hffffffff, 1'($urandom_range(1)));
                    2: set_spring($urandom_range(32'h0004_0000), 0, 1'($urandom_range(1)));
                    default: set_spring($urandom_range(32'h0010_0000),
                                        $urandom_range(32'h0008_0000),
                                        1'($urandom_range(1)));
                endcase
                for (int i = 0; i < RANDOM_ITEMS / 12; i++) begin
                    p = random_pos();
                    send(p, spring_force(p));
                    n++;
                    // hold off once until the pipeline is empty
                    if (ph == 1 && s == 1 && i == 20) begin
                        pos_if.valid <= 1'b0;
                        while (expected_forces.size() != 0) @(posedge i_clk);
                    end
                end
            end
        end
        pos_if.valid <= 1'b0;
        drain();

        if (expected_forces.size() != 0) begin
            $error("%0d force results never arrived", expected_forces.size());
            errors++;
        end
        $display("%0d directed and %0d random requests, %0d results checked",
                 directed.size(), n, results_seen);
        $display("slack bungee results %0d, saturated x results %0d, mismatches %0d",
                 slack_seen, saturated_seen, errors);
        if (errors == 0) begin
            $display("** spring_force_vector_top: PASSED **");
        end else begin
            $display("** spring_force_vector_top: FAILED **");
        end
        $finish;
    end

endmodule
